/* hw/rtl/esckm_pkg.sv */
// esckm_pkg: shared types and codes for the escape sequence keycode matcher
// item and result structs, table entry layout, command and result kinds
// no dependencies
`default_nettype none

package esckm_pkg;

    localparam int PATTERN_MAX = 5;
    localparam int PADDR_W     = 3;

    localparam logic [2:0] LEN_MAX = 3'd5;
    localparam logic [1:0] CNT_MAX = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_KEY  = 1'b1;

    localparam logic KIND_KEY = 1'b0;
    localparam logic KIND_ERR = 1'b1;

    localparam logic [0:0] REG_ENTRIES_IN_USE = 1'b0;

    typedef struct packed {
        logic       cmd;
        logic [6:0] entry_index;
        logic [7:0] pattern_byte0;
        logic [7:0] pattern_byte1;
        logic [7:0] pattern_byte2;
        logic [7:0] pattern_byte3;
        logic [7:0] pattern_byte4;
        logic [2:0] pattern_length;
        logic [1:0] keycode_count;
        logic [7:0] first_keycode;
        logic [7:0] second_keycode;
        logic [7:0] key_byte;
    } in_item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] keycode;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [PATTERN_MAX-1:0][7:0] pattern;
        logic [2:0]                  length;
        logic [7:0]                  key1;
        logic [7:0]                  key0;
        logic [1:0]                  count;
    } entry_t;

endpackage

`default_nettype wire

/* hw/rtl/esckm_apb.sv */
// esckm_apb: configuration register file behind an apb-style port
// holds entries_in_use; uses esckm_pkg
`default_nettype none

module esckm_apb (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [esckm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output logic      [7:0]                   entries_in_use
);
    import esckm_pkg::*;

    logic [7:0] entries_reg;
    logic       sel_entries;

    assign sel_entries    = (paddr[2] == REG_ENTRIES_IN_USE);
    assign pready         = 1'b1;
    assign entries_in_use = entries_reg;
    assign prdata         = sel_entries ? {24'd0, entries_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= 8'd0;
        end else if (psel && penable && pwrite && sel_entries) begin
            entries_reg <= pwdata[7:0];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/esckm_table.sv */
// esckm_table: entry memory and candidate bit memory, each with a registered read
// port; both read at the same address; uses esckm_pkg
`default_nettype none

module esckm_table #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic                aclk,
    input  wire logic                wr_en,
    input  wire logic [AW-1:0]       wr_addr,
    input  wire esckm_pkg::entry_t   wr_data,
    input  wire logic                cand_we,
    input  wire logic [AW-1:0]       cand_waddr,
    input  wire logic                cand_wdata,
    input  wire logic                rd_en,
    input  wire logic [AW-1:0]       rd_addr,
    output esckm_pkg::entry_t        rd_data,
    output logic                     cand_rd_data
);
    import esckm_pkg::*;

    entry_t entry_mem [DEPTH];
    logic   cand_mem  [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= entry_mem[rd_addr];
        end
    end

    // written one entry behind the read pointer, so never the entry being read
    always_ff @(posedge aclk) begin
        if (cand_we) begin
            cand_mem[cand_waddr] <= cand_wdata;
        end
        if (rd_en) begin
            cand_rd_data <= cand_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/esckm_out_queue.sv */
// esckm_out_queue: two-slot result queue in front of the result channel
// loaded with all results of one key byte at once; uses esckm_pkg
`default_nettype none

module esckm_out_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  load,
    input  wire logic [1:0]            load_cnt,
    input  wire esckm_pkg::out_item_t  item0,
    input  wire esckm_pkg::out_item_t  item1,
    output logic                       empty,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output esckm_pkg::out_item_t       m_item
);
    import esckm_pkg::*;

    logic [1:0] count_reg;
    out_item_t  slot0_reg;
    out_item_t  slot1_reg;
    logic       pop;

    assign empty   = (count_reg == 2'd0);
    assign m_valid = !empty;
    assign m_item  = slot0_reg;
    assign pop     = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (load) begin
            count_reg <= load_cnt;
        end else if (pop) begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot0_reg <= item0;
            slot1_reg <= item1;
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

`ifndef ASSERT_OFF
    a_load_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (count_reg == 2'd0) && (load_cnt != 2'd0))
        else $error("result queue loaded while not empty or with no results");
`endif

endmodule

`default_nettype wire

/* hw/rtl/escape_sequence_keycode_matcher_core.sv */
// escape_sequence_keycode_matcher_core: terminal key byte to keycode decoder
//
// s_ channel takes requests: cmd load writes one table entry in the accept
// cycle; cmd key presents one received byte. m_ channel returns zero to two
// results per key request: keycode events or one no-match error, last_of_run
// marking the final result of a key byte.
// apb port: register 0 (byte address 0) is entries_in_use, the number of
// table entries scanned from entry zero; write it only while the block idles.
// a key byte walks the table through the entry memory read port, one entry per
// cycle, through all TABLE_ENTRIES entries for a partial match or a no-match
// error and up to entry index when entry index completes; with no keycodes it
// returns straight to idle, and a byte with results passes through the emit
// state, which loads the output queue; the first result is valid from the
// cycle in which the next request can be accepted.
// the output queue holds the results of one key byte, so the next request is
// taken while they wait; a further key byte that produces results waits for
// the queue to drain when the receiver stalls.
// reset clears the position and control state; table contents stay undefined
// until loaded and need no clearing pass.
`default_nettype none

module escape_sequence_keycode_matcher_core #(
    parameter int TABLE_ENTRIES = 128
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire esckm_pkg::in_item_t           s_item,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output esckm_pkg::out_item_t               m_item,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [esckm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);
    import esckm_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [7:0] entries_in_use;

    logic [1:0]       state_reg, state_next;
    logic [2:0]       pos_reg, pos_next;
    logic [7:0]       key_reg, key_next;
    logic [2:0]       scan_pos_reg, scan_pos_next;
    logic             pos_zero_reg, pos_zero_next;
    logic [CNT_W-1:0] scan_lim_reg, scan_lim_next;
    logic [IDX_W-1:0] issue_idx_reg, issue_idx_next;
    logic             issue_on_reg, issue_on_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             matched_reg, matched_next;
    out_item_t        res0_reg, res0_next;
    out_item_t        res1_reg, res1_next;
    logic [1:0]       res_cnt_reg, res_cnt_next;

    logic       in_acc;
    logic       load_fire;
    entry_t     wr_entry;
    entry_t     rd_entry;
    logic       cand_rd;
    logic       cand;
    logic       in_scan;
    logic       hit;
    logic       complete;
    logic       cand_we;
    logic       cand_wdata;
    logic       rd_en;
    logic [2:0] pos_eff;
    logic       q_empty;
    logic       q_load;

    esckm_apb u_apb (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .entries_in_use (entries_in_use)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign load_fire = in_acc && (s_item.cmd == CMD_LOAD) &&
                       (32'(s_item.entry_index) < 32'(TABLE_ENTRIES));

    always_comb begin
        wr_entry.pattern[0] = s_item.pattern_byte0;
        wr_entry.pattern[1] = s_item.pattern_byte1;
        wr_entry.pattern[2] = s_item.pattern_byte2;
        wr_entry.pattern[3] = s_item.pattern_byte3;
        wr_entry.pattern[4] = s_item.pattern_byte4;
        wr_entry.length     = (s_item.pattern_length > LEN_MAX) ? LEN_MAX
                                                                : s_item.pattern_length;
        wr_entry.count      = (s_item.keycode_count > CNT_MAX) ? CNT_MAX
                                                               : s_item.keycode_count;
        wr_entry.key0       = s_item.first_keycode;
        wr_entry.key1       = s_item.second_keycode;
    end

    assign rd_en = (state_reg == ST_SCAN) && issue_on_reg;

    // compare stage: entry data arrives in the cycle after its read
    assign cand     = pos_zero_reg || cand_rd;
    assign in_scan  = (CNT_W'(cmp_idx_reg) < scan_lim_reg);
    assign hit      = cand && (rd_entry.length > scan_pos_reg) &&
                      (rd_entry.pattern[scan_pos_reg] == key_reg);
    assign complete = hit && (rd_entry.length == scan_pos_reg + 3'd1);

    // entries past the scan limit are set again at the start of a sequence
    assign cand_we    = (state_reg == ST_SCAN) && cmp_valid_reg;
    assign cand_wdata = in_scan ? hit : cand;

    esckm_table #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_table (
        .aclk         (aclk),
        .wr_en        (load_fire),
        .wr_addr      (IDX_W'(s_item.entry_index)),
        .wr_data      (wr_entry),
        .cand_we      (cand_we),
        .cand_waddr   (cmp_idx_reg),
        .cand_wdata   (cand_wdata),
        .rd_en        (rd_en),
        .rd_addr      (issue_idx_reg),
        .rd_data      (rd_entry),
        .cand_rd_data (cand_rd)
    );

    assign pos_eff = (pos_reg >= LEN_MAX) ? 3'd0 : pos_reg;

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        scan_pos_next  = scan_pos_reg;
        pos_zero_next  = pos_zero_reg;
        scan_lim_next  = scan_lim_reg;
        issue_idx_next = issue_idx_reg;
        issue_on_next  = issue_on_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = 1'b0;
        matched_next   = matched_reg;
        res0_next      = res0_reg;
        res1_next      = res1_reg;
        res_cnt_next   = res_cnt_reg;
        q_load         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc && (s_item.cmd == CMD_KEY)) begin
                    key_next       = s_item.key_byte;
                    scan_pos_next  = pos_eff;
                    pos_zero_next  = (pos_eff == 3'd0);
                    if (32'(entries_in_use) > 32'(TABLE_ENTRIES)) begin
                        scan_lim_next = CNT_W'(TABLE_ENTRIES);
                    end else begin
                        scan_lim_next = CNT_W'(entries_in_use);
                    end
                    issue_idx_next = '0;
                    issue_on_next  = 1'b1;
                    matched_next   = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue_on_reg) begin
                    cmp_idx_next   = issue_idx_reg;
                    cmp_valid_next = 1'b1;
                    if (issue_idx_reg == LAST_IDX) begin
                        issue_on_next = 1'b0;
                    end else begin
                        issue_idx_next = issue_idx_reg + IDX_W'(1);
                    end
                end
                if (cmp_valid_reg) begin
                    if (in_scan && hit) begin
                        matched_next = 1'b1;
                    end
                    if (in_scan && complete) begin
                        // first full match wins, the rest of the table is skipped
                        pos_next       = 3'd0;
                        issue_on_next  = 1'b0;
                        cmp_valid_next = 1'b0;
                        res0_next      = '{result_kind: KIND_KEY, keycode: rd_entry.key0,
                                           last_of_run: (rd_entry.count == 2'd1)};
                        res1_next      = '{result_kind: KIND_KEY, keycode: rd_entry.key1,
                                           last_of_run: 1'b1};
                        res_cnt_next   = rd_entry.count;
                        state_next     = (rd_entry.count == 2'd0) ? ST_IDLE : ST_EMIT;
                    end else if (cmp_idx_reg == LAST_IDX) begin
                        cmp_valid_next = 1'b0;
                        if (matched_reg || (in_scan && hit)) begin
                            pos_next   = scan_pos_reg + 3'd1;
                            state_next = ST_IDLE;
                        end else begin
                            pos_next     = 3'd0;
                            res0_next    = '{result_kind: KIND_ERR, keycode: 8'd0,
                                             last_of_run: 1'b1};
                            res_cnt_next = 2'd1;
                            state_next   = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (q_empty) begin
                    q_load     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= 3'd0;
            issue_on_reg  <= 1'b0;
            cmp_valid_reg <= 1'b0;
            matched_reg   <= 1'b0;
            res_cnt_reg   <= 2'd0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            issue_on_reg  <= issue_on_next;
            cmp_valid_reg <= cmp_valid_next;
            matched_reg   <= matched_next;
            res_cnt_reg   <= res_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        scan_pos_reg  <= scan_pos_next;
        pos_zero_reg  <= pos_zero_next;
        scan_lim_reg  <= scan_lim_next;
        issue_idx_reg <= issue_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        res0_reg      <= res0_next;
        res1_reg      <= res1_next;
    end

    esckm_out_queue u_out_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (q_load),
        .load_cnt (res_cnt_reg),
        .item0    (res0_reg),
        .item1    (res1_reg),
        .empty    (q_empty),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

`ifndef ASSERT_OFF
    a_key_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && (s_item.cmd == CMD_KEY)) |=> (state_reg == ST_SCAN) && issue_on_reg)
        else $error("key request did not start a table scan");

    a_error_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_item.result_kind == KIND_ERR)) |->
            (m_item.keycode == 8'd0) && m_item.last_of_run)
        else $error("no-match result with nonzero keycode or not last");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_pos_reg < LEN_MAX) && (pos_reg < LEN_MAX))
        else $error("match position beyond longest pattern");
`endif

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for escape_sequence_keycode_matcher_core
// drives table loads and key bytes, predicts keycode events and no-match errors
// depends on esckm_pkg and the core module with its submodules

module testbench;
    import esckm_pkg::*;

    localparam int TABLE_DEPTH  = 128;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int ITEM_TARGET  = 1100;
    localparam int MAX_PRINTS   = 40;
    localparam int USE_MODEL    = -1;

    localparam logic [7:0] ESC   = 8'd27;
    localparam logic [7:0] CSI   = 8'd91;
    localparam logic [7:0] SS3   = 8'd79;
    localparam logic [7:0] TILDE = 8'd126;
    localparam logic [7:0] SEMI  = 8'd59;

    localparam logic [PADDR_W-1:0] ADDR_ENTRIES_IN_USE = {REG_ENTRIES_IN_USE, 2'b00};
    localparam out_item_t NO_EVENT = '0;

    typedef struct {
        bit          is_setting;
        logic [31:0] setting;
        in_item_t    request;
        int          typed_n;
        out_item_t   typed0;
        out_item_t   typed1;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_item;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_item;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // decoder copy: table, candidates, position and scan size
    logic [7:0] tbl_pattern [TABLE_DEPTH][PATTERN_MAX];
    logic [2:0] tbl_length  [TABLE_DEPTH];
    logic [1:0] tbl_count   [TABLE_DEPTH];
    logic [7:0] tbl_code0   [TABLE_DEPTH];
    logic [7:0] tbl_code1   [TABLE_DEPTH];
    bit         candidate   [TABLE_DEPTH];
    int unsigned seq_pos;
    logic [7:0]  entries_shadow;

    out_item_t predicted_events [$];
    out_item_t expected_events  [$];
    stim_row_t directed_rows    [$];

    int cycle_count     = 0;
    int items_sent      = 0;
    int keys_sent       = 0;
    int loads_sent      = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int table_settings  = 0;

    wire quiet_window = (items_sent >= 450) && (items_sent < 650);

    escape_sequence_keycode_matcher_core #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("run stopped at cycle limit %0d", CYCLE_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= quiet_window || ($urandom_range(0, 99) >= 6);
    end

    function automatic out_item_t make_event(input logic kind, input logic [7:0] code,
                                             input logic last);
        out_item_t ev;
        ev.result_kind = kind;
        ev.keycode     = code;
        ev.last_of_run = last;
        return ev;
    endfunction

    function automatic in_item_t random_bits();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    function automatic in_item_t key_request(input logic [7:0] key);
        in_item_t it;
        it = random_bits();
        it.cmd = CMD_KEY;
        it.key_byte = key;
        return it;
    endfunction

    function automatic in_item_t load_request(input logic [6:0] idx,
                                              input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2, input logic [7:0] b3,
                                              input logic [7:0] b4, input logic [2:0] len,
                                              input logic [1:0] cnt, input logic [7:0] k0,
                                              input logic [7:0] k1);
        in_item_t it;
        it = random_bits();
        it.cmd            = CMD_LOAD;
        it.entry_index    = idx;
        it.pattern_byte0  = b0;
        it.pattern_byte1  = b1;
        it.pattern_byte2  = b2;
        it.pattern_byte3  = b3;
        it.pattern_byte4  = b4;
        it.pattern_length = len;
        it.keycode_count  = cnt;
        it.first_keycode  = k0;
        it.second_keycode = k1;
        return it;
    endfunction

    // bytes that show up after ESC [ or ESC O in real terminal sequences
    function automatic logic [7:0] seq_char();
        case ($urandom_range(0, 11))
            0:       return "1";
            1:       return "2";
            2:       return "3";
            3:       return "5";
            4:       return SEMI;
            5:       return TILDE;
            6:       return "A";
            7:       return "B";
            8:       return "C";
            9:       return "D";
            10:      return "H";
            default: return "F";
        endcase
    endfunction

    function automatic in_item_t fresh_entry(input logic [6:0] idx);
        in_item_t it;
        int roll;
        roll = $urandom_range(0, 99);
        it = random_bits();
        it.cmd = CMD_LOAD;
        it.entry_index = idx;
        // some entries keep raw length and count, saturation and dead entries included
        if (roll < 10)
            return it;
        if (roll < 30) begin
            it.pattern_length = 3'd1;
            it.pattern_byte0  = 8'($urandom_range(32, 126));
        end else begin
            it.pattern_length = 3'($urandom_range(2, 5));
            it.pattern_byte0  = ESC;
            it.pattern_byte1  = $urandom_range(0, 1) ? CSI : SS3;
            it.pattern_byte2  = seq_char();
            it.pattern_byte3  = seq_char();
            it.pattern_byte4  = seq_char();
        end
        it.keycode_count = 2'($urandom_range(1, 2));
        return it;
    endfunction

    function automatic void add_row(input in_item_t it, input int n, input out_item_t a,
                                    input out_item_t b);
        stim_row_t row;
        row.is_setting = 1'b0;
        row.setting    = '0;
        row.request    = it;
        row.typed_n    = n;
        row.typed0     = a;
        row.typed1     = b;
        directed_rows.push_back(row);
    endfunction

    // decode one accepted request into predicted_events
    function automatic void predict_request(input in_item_t it);
        int unsigned scan;
        int unsigned hit;
        int unsigned i;
        bit partial;
        logic [1:0] n;
        if (it.cmd == CMD_LOAD) begin
            tbl_pattern[it.entry_index][0] = it.pattern_byte0;
            tbl_pattern[it.entry_index][1] = it.pattern_byte1;
            tbl_pattern[it.entry_index][2] = it.pattern_byte2;
            tbl_pattern[it.entry_index][3] = it.pattern_byte3;
            tbl_pattern[it.entry_index][4] = it.pattern_byte4;
            tbl_length[it.entry_index] = (it.pattern_length > LEN_MAX) ? LEN_MAX
                                                                       : it.pattern_length;
            tbl_count[it.entry_index]  = (it.keycode_count > CNT_MAX) ? CNT_MAX
                                                                      : it.keycode_count;
            tbl_code0[it.entry_index]  = it.first_keycode;
            tbl_code1[it.entry_index]  = it.second_keycode;
            return;
        end
        if (seq_pos >= PATTERN_MAX)
            seq_pos = 0;
        scan = (entries_shadow > TABLE_DEPTH) ? TABLE_DEPTH : entries_shadow;
        if (seq_pos == 0) begin
            for (i = 0; i < TABLE_DEPTH; i++)
                candidate[i] = 1'b1;
        end
        hit = TABLE_DEPTH;
        partial = 1'b0;
        for (i = 0; i < scan; i++) begin
            if (candidate[i] && tbl_length[i] > seq_pos &&
                tbl_pattern[i][seq_pos] == it.key_byte) begin
                partial = 1'b1;
                if (tbl_length[i] == seq_pos + 1) begin
                    hit = i;
                    break;
                end
            end else begin
                candidate[i] = 1'b0;
            end
        end
        if (hit < TABLE_DEPTH) begin
            seq_pos = 0;
            n = tbl_count[hit];
            if (n != 0)
                predicted_events.push_back(make_event(KIND_KEY, tbl_code0[hit], n == 2'd1));
            if (n == 2'd2)
                predicted_events.push_back(make_event(KIND_KEY, tbl_code1[hit], 1'b1));
        end else if (partial) begin
            seq_pos = seq_pos + 1;
        end else begin
            seq_pos = 0;
            predicted_events.push_back(make_event(KIND_ERR, 8'h00, 1'b1));
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic send_request(input in_item_t it, input int typed_n, input out_item_t t0,
                                input out_item_t t1);
        if (!quiet_window) begin
            while ($urandom_range(0, 99) < 6) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted_events.delete();
        predict_request(it);
        if (typed_n == USE_MODEL) begin
            foreach (predicted_events[k])
                expected_events.push_back(predicted_events[k]);
        end else begin
            if (typed_n > 0)
                expected_events.push_back(t0);
            if (typed_n > 1)
                expected_events.push_back(t1);
        end
        items_sent++;
        if (it.cmd == CMD_KEY)
            keys_sent++;
        else
            loads_sent++;
    endtask

    // a partial match gives no result, so allow a full table walk after the last one
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_entries_in_use(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ENTRIES_IN_USE;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        entries_shadow = value[7:0];
        table_settings++;
    endtask

    // send an entry's pattern; a broken one stops early and ends in a stray byte
    task automatic send_sequence(input int unsigned entry, input bit broken);
        int unsigned len;
        int unsigned cut;
        int unsigned i;
        len = (tbl_length[entry] == 0) ? 1 : tbl_length[entry];
        cut = broken ? $urandom_range(0, len - 1) : len;
        for (i = 0; i < cut; i++)
            send_request(key_request(tbl_pattern[entry][i]), USE_MODEL, NO_EVENT, NO_EVENT);
        if (broken)
            send_request(key_request($urandom_range(0, 1) ? seq_char() : 8'($urandom)),
                         USE_MODEL, NO_EVENT, NO_EVENT);
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d code %02h last %0d",
                                          m_item.result_kind, m_item.keycode,
                                          m_item.last_of_run));
            end else begin
                want = expected_events.pop_front();
                results_checked++;
                if (m_item.result_kind !== want.result_kind)
                    report_mismatch($sformatf("result_kind %0d, expected %0d",
                                              m_item.result_kind, want.result_kind));
                if (m_item.keycode !== want.keycode)
                    report_mismatch($sformatf("keycode %02h, expected %02h",
                                              m_item.keycode, want.keycode));
                if (m_item.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %0d, expected %0d",
                                              m_item.last_of_run, want.last_of_run));
            end
        end
    end

    initial begin
        stim_row_t   row;
        int unsigned plan [8];
        int unsigned usable;
        int          goal;
        int          phase;
        int          roll;
        int          i;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        m_ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        seq_pos = 0;
        entries_shadow = 8'd0;
        for (i = 0; i < TABLE_DEPTH; i++)
            candidate[i] = 1'b1;

        // no entries in use after reset: any byte is a no-match
        add_row(key_request(ESC), 1, make_event(KIND_ERR, 8'h00, 1'b1), NO_EVENT);
        add_row(load_request(7'd0, ESC, CSI, "A", 8'hAA, 8'h55, 3'd3, 2'd1, 8'h11, 8'hEE),
                0, NO_EVENT, NO_EVENT);
        add_row(load_request(7'd1, ESC, CSI, "1", TILDE, 8'h55, 3'd4, 2'd2, 8'h22, 8'h23),
                0, NO_EVENT, NO_EVENT);
        // length and count above range saturate to five and two
        add_row(load_request(7'd2, ESC, CSI, "1", SEMI, "2", 3'd7, 2'd3, 8'hFF, 8'h00),
                0, NO_EVENT, NO_EVENT);
        add_row(load_request(7'd3, ESC, CSI, "A", 8'hFF, 8'hFF, 3'd0, 2'd1, 8'h33, 8'h34),
                0, NO_EVENT, NO_EVENT);
        add_row(load_request(7'd4, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd1, 2'd0, 8'h44, 8'h45),
                0, NO_EVENT, NO_EVENT);
        add_row(load_request(7'd5, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 2'd2, 8'h01, 8'hFE),
                0, NO_EVENT, NO_EVENT);
        // same pattern as entry zero, never reached since the first full match wins
        add_row(load_request(7'd6, ESC, CSI, "A", 8'h00, 8'h00, 3'd3, 2'd1, 8'h66, 8'h67),
                0, NO_EVENT, NO_EVENT);
        row.is_setting = 1'b1;
        row.setting    = 32'd7;
        row.request    = '0;
        row.typed_n    = 0;
        row.typed0     = NO_EVENT;
        row.typed1     = NO_EVENT;
        directed_rows.push_back(row);
        add_row(key_request(ESC), USE_MODEL, NO_EVENT, NO_EVENT);
        add_row(key_request(CSI), USE_MODEL, NO_EVENT, NO_EVENT);
        add_row(key_request("A"), 1, make_event(KIND_KEY, 8'h11, 1'b1), NO_EVENT);
        add_row(key_request(ESC), USE_MODEL, NO_EVENT, NO_EVENT);
        add_row(key_request(CSI), USE_MODEL, NO_EVENT, NO_EVENT);
        add_row(key_request("1"), USE_MODEL, NO_EVENT, NO_EVENT);
        add_row(key_request(TILDE), USE_MODEL, NO_EVENT, NO_EVENT);
        add_row(key_request(ESC), USE_MODEL, NO_EVENT, NO_EVENT);
        add_row(key_request(CSI), USE_MODEL, NO_EVENT, NO_EVENT);
        add_row(key_request("1"), USE_MODEL, NO_EVENT, NO_EVENT);
        add_row(key_request(SEMI), USE_MODEL, NO_EVENT, NO_EVENT);
        add_row(key_request("2"), 2, make_event(KIND_KEY, 8'hFF, 1'b0),
                make_event(KIND_KEY, 8'h00, 1'b1));
        // full match on a zero-count entry gives nothing
        add_row(key_request(8'h00), 0, NO_EVENT, NO_EVENT);
        add_row(key_request(8'hFF), 2, make_event(KIND_KEY, 8'h01, 1'b0),
                make_event(KIND_KEY, 8'hFE, 1'b1));
        add_row(key_request(ESC), USE_MODEL, NO_EVENT, NO_EVENT);
        add_row(key_request(CSI), USE_MODEL, NO_EVENT, NO_EVENT);
        add_row(key_request("B"), 1, make_event(KIND_ERR, 8'h00, 1'b1), NO_EVENT);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_setting) begin
                settle();
                write_entries_in_use(directed_rows[r].setting);
            end else begin
                send_request(directed_rows[r].request, directed_rows[r].typed_n,
                             directed_rows[r].typed0, directed_rows[r].typed1);
            end
        end

        // fill the whole table so any scan size only reads loaded entries
        for (i = 0; i < TABLE_DEPTH; i++)
            send_request(fresh_entry(7'(i)), USE_MODEL, NO_EVENT, NO_EVENT);

        plan = '{128, 1, 255, 0, 100, 128, 2, 64};
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            settle();
            write_entries_in_use(phase < 8 ? plan[phase] : $urandom_range(0, 255));
            usable = (entries_shadow > TABLE_DEPTH) ? TABLE_DEPTH : entries_shadow;
            goal = items_sent + $urandom_range(80, 160);
            while (items_sent < goal && items_sent < ITEM_TARGET) begin
                roll = $urandom_range(0, 99);
                if (roll < 6)
                    send_request(fresh_entry(7'($urandom_range(0, TABLE_DEPTH - 1))),
                                 USE_MODEL, NO_EVENT, NO_EVENT);
                else if (roll < 18 || usable == 0)
                    send_request(key_request(8'($urandom)), USE_MODEL, NO_EVENT, NO_EVENT);
                else
                    send_sequence($urandom_range(0, usable - 1), roll < 30);
            end
            phase++;
        end

        settle();
        $display("sent %0d requests: %0d key bytes and %0d table loads, %0d scan sizes",
                 items_sent, keys_sent, loads_sent, table_settings);
        $display("checked %0d results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
